// ----- rtl/rrct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrct_pkg: shared types and constants
// Field widths, defaults and the op codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rrct_pkg;

   localparam int TIME_WIDTH       = 20;
   localparam int QUANTUM_WIDTH    = 16;
   localparam int IN_BURST_WIDTH   = 16;
   localparam int INDEX_WIDTH      = 4;
   localparam int RSP_DATA_WIDTH   = 48;
   localparam int DEF_MAX_JOBS     = 16;
   localparam int DEF_BURST_WIDTH  = 16;

   localparam logic [QUANTUM_WIDTH-1:0] QUANTUM_RESET = QUANTUM_WIDTH'(2);
   localparam logic [TIME_WIDTH-1:0]    TIME_MAX      = {TIME_WIDTH{1'b1}};

   typedef enum logic [0:0] {
      ALU_SERVICE = 1'b0,   // one turn of service, advance the clock
      ALU_WAIT    = 1'b1    // completion minus burst, floor at zero
   } alu_op_type;

endpackage : rrct_pkg
`default_nettype wire

// ----- rtl/round_robin_completion_times.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_completion_times: round-robin schedule of one batch of jobs
// Loads burst times, runs the round-robin passes, streams per-job times out.
// ----------------------------------------------------------------------------
// Load one burst time per req word, one word per cycle; the word with tlast
// closes the batch. Words past MAX_JOBS are dropped and every result of that
// batch carries tuser = 1. After the closing word, req_tready stays low while a
// sequencer walks the jobs through one shared compare/add unit: each job visit
// is a RAM read, then an update, and the schedule makes P passes over the N jobs
// of the batch, where P = max(1, ceil(max burst / quantum)). Results then leave
// in job order, each read, given its waiting time and held until rsp_tready; the
// next is read only once the one before it is taken. The next batch is taken once
// the result with tlast has gone. A quantum of zero acts as one; the clock
// saturates at 2^20 - 1. Write csr only while idle.
// ----------------------------------------------------------------------------
module round_robin_completion_times
   import rrct_pkg::*;
#(
   parameter int MAX_JOBS    = DEF_MAX_JOBS,
   parameter int BURST_WIDTH = DEF_BURST_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration: service quantum per turn
   input  wire logic                      csr_wen,
   input  wire logic [QUANTUM_WIDTH-1:0]  csr_wdata,
   // job words
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [IN_BURST_WIDTH-1:0] req_tdata,   // [15:0] burst_time
   input  wire logic                      req_tlast,   // last_item
   // result words
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [3:0] job_index, [23:4] turnaround_time, [43:24] waiting_time, [47:44] zero
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                           rsp_tuser,   // overflow
   output logic                           rsp_tlast    // last_result
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SIM_RD   = 6'b000010,
      ST_SIM_EX   = 6'b000100,
      ST_OUT_RD   = 6'b001000,
      ST_OUT_EX   = 6'b010000,
      ST_OUT_HOLD = 6'b100000
   } state_type;

   // control state
   state_type                state_ff, state_in;
   logic [QUANTUM_WIDTH-1:0] quantum_ff, quantum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [TIME_WIDTH-1:0]    clock_ff, clock_in;
   logic                     dropped_ff, dropped_in;
   logic                     first_pass_ff, first_pass_in;
   logic                     busy_ff, busy_in;

   // result payload
   logic [INDEX_WIDTH-1:0]   rsp_index_ff, rsp_index_in;
   logic [TIME_WIDTH-1:0]    rsp_ta_ff, rsp_ta_in;
   logic [TIME_WIDTH-1:0]    rsp_wt_ff, rsp_wt_in;
   logic                     rsp_last_ff, rsp_last_in;

   // RAM ports
   logic                     burst_we;
   logic [BURST_WIDTH-1:0]   burst_rd;
   logic                     remain_we;
   logic [BURST_WIDTH-1:0]   remain_rd;
   logic                     compl_we;
   logic [TIME_WIDTH-1:0]    compl_wdata;
   logic [TIME_WIDTH-1:0]    compl_rd;

   // shared unit
   alu_op_type               alu_op;
   logic [TIME_WIDTH-1:0]    alu_a;
   logic [BURST_WIDTH-1:0]   alu_b;
   logic [QUANTUM_WIDTH-1:0] quantum_eff;
   logic [BURST_WIDTH-1:0]   alu_rem;
   logic [TIME_WIDTH-1:0]    alu_time;

   logic [BURST_WIDTH-1:0]   rem_cur;
   logic [CNT_W-1:0]         idx_plus;
   logic                     last_job;
   logic                     job_busy;

   // --- storage ---------------------------------------------------------------
   rrct_ram #(.WIDTH(BURST_WIDTH), .DEPTH(MAX_JOBS)) u_burst_ram (
      .clock   (clock),
      .wr_en   (burst_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (BURST_WIDTH'(req_tdata)),
      .rd_addr (idx_ff),
      .rd_data (burst_rd)
   );

   rrct_ram #(.WIDTH(BURST_WIDTH), .DEPTH(MAX_JOBS)) u_remain_ram (
      .clock   (clock),
      .wr_en   (remain_we),
      .wr_addr (idx_ff),
      .wr_data (alu_rem),
      .rd_addr (idx_ff),
      .rd_data (remain_rd)
   );

   rrct_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_JOBS)) u_compl_ram (
      .clock   (clock),
      .wr_en   (compl_we),
      .wr_addr (idx_ff),
      .wr_data (compl_wdata),
      .rd_addr (idx_ff),
      .rd_data (compl_rd)
   );

   // --- shared arithmetic -----------------------------------------------------
   // First pass takes the remaining time straight from the burst store, so no
   // copy sweep is needed before the schedule starts.
   assign rem_cur     = first_pass_ff ? burst_rd : remain_rd;
   assign quantum_eff = (quantum_ff == '0) ? QUANTUM_WIDTH'(1) : quantum_ff;
   assign alu_op      = (state_ff == ST_SIM_EX) ? ALU_SERVICE : ALU_WAIT;
   assign alu_a       = (state_ff == ST_SIM_EX) ? clock_ff : compl_rd;
   assign alu_b       = (state_ff == ST_SIM_EX) ? rem_cur : burst_rd;

   rrct_alu #(.BURST_WIDTH(BURST_WIDTH)) u_alu (
      .op          (alu_op),
      .a_time      (alu_a),
      .b_burst     (alu_b),
      .quantum     (quantum_eff),
      .rem_next    (alu_rem),
      .time_result (alu_time)
   );

   assign idx_plus = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_job = (idx_plus == count_ff);

   // --- sequencer -------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      quantum_in    = csr_wen ? csr_wdata : quantum_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      clock_in      = clock_ff;
      dropped_in    = dropped_ff;
      first_pass_in = first_pass_ff;
      busy_in       = busy_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_ta_in     = rsp_ta_ff;
      rsp_wt_in     = rsp_wt_ff;
      rsp_last_in   = rsp_last_ff;
      burst_we      = 1'b0;
      remain_we     = 1'b0;
      compl_we      = 1'b0;
      compl_wdata   = '0;
      job_busy      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // store the burst if there is room, otherwise drop and flag
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  burst_we = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  idx_in        = '0;
                  first_pass_in = 1'b1;
                  busy_in       = 1'b0;
                  state_in      = ST_SIM_RD;
               end
            end
         end

         ST_SIM_RD: begin
            state_in = ST_SIM_EX;
         end

         ST_SIM_EX: begin
            if (rem_cur != '0) begin
               // serve one turn, advance the clock
               remain_we = 1'b1;
               clock_in  = alu_time;
               if (alu_rem == '0) begin
                  compl_we    = 1'b1;
                  compl_wdata = alu_time;
               end else begin
                  job_busy = 1'b1;
               end
            end else if (first_pass_ff) begin
               // zero burst: done at time zero, mark nothing left for later passes
               remain_we   = 1'b1;
               compl_we    = 1'b1;
               compl_wdata = '0;
            end

            if (last_job) begin
               idx_in = '0;
               if (busy_ff || job_busy) begin
                  first_pass_in = 1'b0;
                  busy_in       = 1'b0;
                  state_in      = ST_SIM_RD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end else begin
               idx_in   = idx_plus[IDX_W-1:0];
               busy_in  = busy_ff || job_busy;
               state_in = ST_SIM_RD;
            end
         end

         ST_OUT_RD: begin
            state_in = ST_OUT_EX;
         end

         ST_OUT_EX: begin
            rsp_index_in = INDEX_WIDTH'(idx_ff);
            rsp_ta_in    = compl_rd;
            rsp_wt_in    = alu_time;
            rsp_last_in  = last_job;
            state_in     = ST_OUT_HOLD;
         end

         ST_OUT_HOLD: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  // batch done: clear for the next one
                  count_in   = '0;
                  clock_in   = '0;
                  dropped_in = 1'b0;
                  idx_in     = '0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_plus[IDX_W-1:0];
                  state_in = ST_OUT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         quantum_ff    <= QUANTUM_RESET;
         count_ff      <= '0;
         idx_ff        <= '0;
         clock_ff      <= '0;
         dropped_ff    <= 1'b0;
         first_pass_ff <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         quantum_ff    <= quantum_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         clock_ff      <= clock_in;
         dropped_ff    <= dropped_in;
         first_pass_ff <= first_pass_in;
         busy_ff       <= busy_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_ta_ff    <= rsp_ta_in;
      rsp_wt_ff    <= rsp_wt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // --- ports -----------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT_HOLD);
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_wt_ff, rsp_ta_ff, rsp_index_ff});
   assign rsp_tuser  = dropped_ff;
   assign rsp_tlast  = rsp_last_ff;

   // --- assertions ------------------------------------------------------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and output sides active together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_JOBS))
      else $error("job count beyond capacity");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         count_ff == '0 && clock_ff == '0 && !dropped_ff && req_tready)
      else $error("batch state not cleared after final result");

   a_sim_has_jobs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIM_EX |-> count_ff != '0)
      else $error("schedule running on an empty batch");

endmodule : round_robin_completion_times
`default_nettype wire

// ----- rtl/rrct_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrct_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : rrct_ram
`default_nettype wire

// ----- rtl/rrct_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrct_alu: shared arithmetic unit
// One compare and one adder, used for service turns and waiting times.
// ----------------------------------------------------------------------------
module rrct_alu
   import rrct_pkg::*;
#(
   parameter int BURST_WIDTH = DEF_BURST_WIDTH
) (
   input  wire alu_op_type               op,
   input  wire logic [TIME_WIDTH-1:0]    a_time,
   input  wire logic [BURST_WIDTH-1:0]   b_burst,
   input  wire logic [QUANTUM_WIDTH-1:0] quantum,
   output logic      [BURST_WIDTH-1:0]   rem_next,
   output logic      [TIME_WIDTH-1:0]    time_result
);

   localparam int CMP_W = (BURST_WIDTH > QUANTUM_WIDTH) ? BURST_WIDTH : QUANTUM_WIDTH;
   localparam int SUM_W = ((TIME_WIDTH > BURST_WIDTH) ? TIME_WIDTH : BURST_WIDTH) + 1;

   logic [BURST_WIDTH-1:0] run;
   logic [SUM_W-1:0]       a_ext;
   logic [SUM_W-1:0]       addend;
   logic [SUM_W-1:0]       sum;

   // run = min(remaining, quantum)
   always_comb begin
      if (CMP_W'(b_burst) > CMP_W'(quantum)) begin
         run = BURST_WIDTH'(quantum);
      end else begin
         run = b_burst;
      end
   end

   assign a_ext  = SUM_W'(a_time);
   assign addend = (op == ALU_WAIT) ? (SUM_W'(0) - SUM_W'(b_burst)) : SUM_W'(run);
   assign sum    = a_ext + addend;

   always_comb begin
      case (op)
         ALU_SERVICE: begin
            rem_next = b_burst - run;
            if (sum > SUM_W'(TIME_MAX)) begin
               time_result = TIME_MAX;
            end else begin
               time_result = sum[TIME_WIDTH-1:0];
            end
         end
         ALU_WAIT: begin
            rem_next = b_burst;
            // top bit set means burst exceeded completion: floor at zero
            time_result = sum[SUM_W-1] ? '0 : sum[TIME_WIDTH-1:0];
         end
         default: begin
            rem_next    = b_burst;
            time_result = '0;
         end
      endcase
   end

endmodule : rrct_alu
`default_nettype wire

// ----- bench/round_robin_completion_times_tb.sv -----
// ----------------------------------------------------------------------------
// round_robin_completion_times_tb: self-checking bench for the round-robin block
// Streams batches of burst times under several quantum settings, predicts the
// per-job completion and waiting times, and checks every result word in order.
// ----------------------------------------------------------------------------
module round_robin_completion_times_tb
   import rrct_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 16;    // pause before csr writes and at the end
   localparam int DIRECTED_WORDS = 23;
   localparam int RANDOM_WORDS   = 480 - DIRECTED_WORDS;
   localparam int CALM_AFTER     = DIRECTED_WORDS + RANDOM_WORDS - 60;
   localparam int MAX_PASSES     = 8;     // keeps random schedules short

   // Result word as it sits on rsp_tdata, lowest field last in the list.
   typedef struct packed {
      logic [3:0]             pad;
      logic [TIME_WIDTH-1:0]  waiting;
      logic [TIME_WIDTH-1:0]  turnaround;
      logic [INDEX_WIDTH-1:0] job_index;
   } rsp_word_type;

   typedef struct {
      rsp_word_type word;
      logic         overflow;
      logic         last;
   } job_result_type;

   // Scoreboard: mirrors the batch state and holds the job times still due.
   class completion_board;
      logic [QUANTUM_WIDTH-1:0]  quantum;
      logic [IN_BURST_WIDTH-1:0] loaded[$];
      logic                      dropped;
      job_result_type            due[$];
      int                        err_count;

      function new();
         quantum   = QUANTUM_RESET;
         dropped   = 1'b0;
         err_count = 0;
      endfunction

      function void set_quantum(logic [QUANTUM_WIDTH-1:0] value);
         quantum = value;
      endfunction

      function int outstanding();
         return due.size();
      endfunction

      task report(string what);
         if (err_count < 100) $display("mismatch: %s", what);
         err_count++;
      endtask

      // Run the round-robin passes over the loaded batch and queue its results.
      function void close_batch();
         logic [IN_BURST_WIDTH-1:0] left[$];
         logic [TIME_WIDTH-1:0]     done[DEF_MAX_JOBS];
         logic [TIME_WIDTH-1:0]     now;
         logic [QUANTUM_WIDTH:0]    slice;
         logic [QUANTUM_WIDTH:0]    run;
         logic [TIME_WIDTH:0]       sum;
         logic                      busy;
         job_result_type            res;

         slice = (quantum == '0) ? (QUANTUM_WIDTH + 1)'(1) : {1'b0, quantum};
         left  = loaded;
         now   = '0;
         foreach (done[i]) done[i] = '0;
         do begin
            busy = 1'b0;
            foreach (left[i]) begin
               if (left[i] != '0) begin
                  run     = (left[i] > slice) ? slice : {1'b0, left[i]};
                  sum     = {1'b0, now} + run;
                  now     = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_WIDTH-1:0];
                  left[i] = left[i] - run[IN_BURST_WIDTH-1:0];
                  if (left[i] == '0) done[i] = now;
                  else busy = 1'b1;
               end
            end
         end while (busy);

         foreach (loaded[i]) begin
            res.word.pad        = '0;
            res.word.job_index  = i[INDEX_WIDTH-1:0];
            res.word.turnaround = done[i];
            // floor at zero; only a saturated clock could go below
            res.word.waiting    = (done[i] >= loaded[i]) ? done[i] - loaded[i] : '0;
            res.overflow        = dropped;
            res.last            = (i == loaded.size() - 1);
            due.push_back(res);
         end
         loaded.delete();
         dropped = 1'b0;
      endfunction

      function void note_job(logic [IN_BURST_WIDTH-1:0] burst, logic last);
         if (loaded.size() < DEF_MAX_JOBS) loaded.push_back(burst);
         else dropped = 1'b1;
         if (last) close_batch();
      endfunction

      task check_result(rsp_word_type got, logic got_overflow, logic got_last);
         job_result_type want;
         if (due.size() == 0) begin
            report($sformatf("result word job %0d with nothing due", got.job_index));
            return;
         end
         want = due.pop_front();
         if (got.job_index !== want.word.job_index)
            report($sformatf("job_index got %0d want %0d",
                             got.job_index, want.word.job_index));
         if (got.turnaround !== want.word.turnaround)
            report($sformatf("job %0d turnaround got %0d want %0d", want.word.job_index,
                             got.turnaround, want.word.turnaround));
         if (got.waiting !== want.word.waiting)
            report($sformatf("job %0d waiting got %0d want %0d", want.word.job_index,
                             got.waiting, want.word.waiting));
         if (got.pad !== want.word.pad)
            report($sformatf("job %0d pad bits got %h", want.word.job_index, got.pad));
         if (got_overflow !== want.overflow)
            report($sformatf("job %0d overflow got %b want %b", want.word.job_index,
                             got_overflow, want.overflow));
         if (got_last !== want.last)
            report($sformatf("job %0d last got %b want %b", want.word.job_index,
                             got_last, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wen;
   logic [QUANTUM_WIDTH-1:0]  csr_wdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [IN_BURST_WIDTH-1:0] req_tdata;   // [15:0] burst_time
   logic                      req_tlast;   // last_item
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [3:0] job_index, [23:4] turnaround_time, [43:24] waiting_time, [47:44] zero
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;   // overflow
   logic                      rsp_tlast;   // last_result

   completion_board board;
   int  words_sent;
   bit  idle_on;       // random gaps on both sides; cleared for the calm tail
   int  hold_rsp = 0;
   int  quiet_cycles;

   round_robin_completion_times i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drive one job word and hold it until the block takes it. On the closing
   // word, drop valid and step past the edge so the next batch raises it cleanly;
   // the block is busy scheduling then and could not take a word anyway.
   task send_job(input logic [IN_BURST_WIDTH-1:0] burst, input logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= burst;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_job(burst, last);
      words_sent++;
      if (last) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Load a batch of n words; bursts stay within cap so schedules stay short.
   task send_batch(input int n, input int cap);
      int                        pick;
      logic [IN_BURST_WIDTH-1:0] burst;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) burst = '0;
         else if (pick == 1) burst = cap[IN_BURST_WIDTH-1:0];
         else burst = IN_BURST_WIDTH'($urandom_range(0, cap));
         send_job(burst, i == n - 1);
      end
   endtask

   // Write the quantum only once every due result is out and the block is idle.
   task write_quantum(input logic [QUANTUM_WIDTH-1:0] value);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      board.set_quantum(value);
      csr_wen   <= 1'b0;
   endtask

   // Result side: check each accepted word, then decide on the next stall.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         board.check_result(rsp_word_type'(rsp_tdata), rsp_tuser, rsp_tlast);
      if (hold_rsp > 0) begin
         hold_rsp--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         hold_rsp = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: give up after a long run of cycles with no word moving.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("round_robin_completion_times_tb: FAIL");
      $finish;
   end

   initial begin
      int                        kind;
      int                        cap;
      int                        n;
      logic [QUANTUM_WIDTH-1:0]  q;

      board      = new();
      words_sent = 0;
      idle_on    = 1'b1;
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset quantum of 2: mixed batch with a zero burst in the middle,
      // then a batch holding a single zero burst.
      send_job(16'd5, 1'b0);
      send_job(16'd0, 1'b0);
      send_job(16'd3, 1'b1);
      send_job(16'd0, 1'b1);

      // Zero quantum acts as one.
      write_quantum('0);
      send_job(16'd3, 1'b0);
      send_job(16'd1, 1'b1);

      // Widest quantum: full batch, maximum bursts at even job positions, plus one
      // more word, which is dropped but still closes the batch and flags overflow.
      write_quantum({QUANTUM_WIDTH{1'b1}});
      for (int i = 0; i < DEF_MAX_JOBS; i++)
         send_job((i % 2 == 0) ? {IN_BURST_WIDTH{1'b1}} : IN_BURST_WIDTH'($urandom_range(0, 40)),
                  1'b0);
      send_job(IN_BURST_WIDTH'($urandom_range(0, 65535)), 1'b1);

      // Random phases: each picks a quantum and runs several batches. Start with
      // a quantum of one so the smallest setting is always visited.
      kind = 0;
      while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
         case (kind)
            0: q = QUANTUM_WIDTH'(1);
            1: q = '0;
            2: q = {QUANTUM_WIDTH{1'b1}};
            3: q = QUANTUM_WIDTH'($urandom_range(1, 16));
            4: q = QUANTUM_WIDTH'($urandom_range(1, 65535));
            default: q = QUANTUM_RESET;
         endcase
         write_quantum(q);
         cap = (q == '0) ? MAX_PASSES : int'(q) * MAX_PASSES;
         if (cap > 65535) cap = 65535;
         repeat ($urandom_range(3, 8)) begin
            if (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
               if (words_sent >= CALM_AFTER) idle_on = 1'b0;
               if ($urandom_range(0, 7) == 0)
                  n = $urandom_range(DEF_MAX_JOBS + 1, DEF_MAX_JOBS + 4);
               else
                  n = $urandom_range(1, DEF_MAX_JOBS);
               send_batch(n, cap);
            end
         end
         kind = $urandom_range(0, 5);
      end

      // Drain: wait for every due result, then let stray words show up.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.err_count == 0) begin
         $display("round_robin_completion_times_tb: PASS");
      end else begin
         $display("round_robin_completion_times_tb: FAIL");
      end
      $finish;
   end

endmodule
